>>> hdl/setp_pkg.sv
// Shared types, opcodes and constants of the slot execution-time profiler.
`default_nettype none
package setp_pkg;

   localparam int SLOTS_DEF = 16;
   localparam int SLOT_W    = 4;
   localparam int TS_W      = 32;
   localparam int CNT_W     = 32;
   localparam int INTV_W    = 24;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [INTV_W-1:0] SAT_LIMIT = INTV_W'(9999999);

   typedef struct packed {
      logic [1:0]        opcode;
      logic [SLOT_W-1:0] slot;
      logic [TS_W-1:0]   timestamp_us;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]  entry_count;
      logic [INTV_W-1:0] interval_us;
      logic [TS_W-1:0]   last_duration_us;
      logic [TS_W-1:0]   peak_duration_us;
      logic              measured;
   } rsp_type;

   // Per-slot record held in the slot memory.
   typedef struct packed {
      logic [CNT_W-1:0]  start_count;
      logic [TS_W-1:0]   start_time;
      logic [TS_W-1:0]   end_time;
      logic              armed;
      logic [INTV_W-1:0] interval;
      logic [TS_W-1:0]   duration;
      logic [TS_W-1:0]   peak;
   } rec_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

>>> hdl/setp_ctrl.sv
// Controller: sequences accept and read-modify-write of one item at a time.
`default_nettype none
module setp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire setp_pkg::sts_type sts,
   output setp_pkg::cmd_type     cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.commit = (state_ff == ST_EXEC) && sts.rsp_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/setp_dp.sv
// Datapath: slot memory, valid bits, update arithmetic and result register.
`default_nettype none
module setp_dp #(
   parameter int SLOTS = setp_pkg::SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire setp_pkg::req_type req_data,
   input  wire setp_pkg::cmd_type cmd,
   output setp_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output setp_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EXT_W = 9;

   setp_pkg::req_type hold_ff;
   setp_pkg::rec_type rd_ff;
   setp_pkg::rec_type mem_ff [SLOTS];
   setp_pkg::rec_type cur;
   setp_pkg::rec_type rec_new;
   setp_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic [SLOTS-1:0]  base_vld_ff;
   logic [SLOTS-1:0]  base_vld_in;
   logic [SLOTS-1:0]  stat_vld_ff;
   logic [SLOTS-1:0]  stat_vld_in;

   logic [EXT_W-1:0] req_ext;
   logic [EXT_W-1:0] hold_ext;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] hold_idx;
   logic             in_range;
   logic             done;
   logic [setp_pkg::TS_W-1:0] dur;
   logic [setp_pkg::TS_W-1:0] per;

   assign req_ext  = EXT_W'(req_data.slot);
   assign hold_ext = EXT_W'(hold_ff.slot);
   assign req_idx  = req_ext[IDX_W-1:0];
   assign hold_idx = hold_ext[IDX_W-1:0];
   assign in_range = (hold_ext < EXT_W'(SLOTS));

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_comb begin
      cur = rd_ff;
      if (!base_vld_ff[hold_idx]) begin
         cur.start_time = '0;
         cur.end_time   = '0;
         cur.armed      = 1'b0;
      end
      if (!stat_vld_ff[hold_idx] || hold_ff.opcode == setp_pkg::OP_CLEAR) begin
         cur.start_count = '0;
         cur.interval    = '0;
         cur.duration    = '0;
         cur.peak        = '0;
      end
   end

   assign dur = hold_ff.timestamp_us - cur.start_time;
   assign per = hold_ff.timestamp_us - cur.end_time;

   always_comb begin
      rec_new = cur;
      done    = 1'b0;
      case (hold_ff.opcode)
         setp_pkg::OP_START: begin
            rec_new.start_count = cur.start_count + 1'b1;
            rec_new.start_time  = hold_ff.timestamp_us;
            rec_new.armed       = 1'b1;
         end
         setp_pkg::OP_END: begin
            if (cur.armed) begin
               if (per > setp_pkg::TS_W'(setp_pkg::SAT_LIMIT)) begin
                  rec_new.interval = setp_pkg::SAT_LIMIT;
               end else begin
                  rec_new.interval = per[setp_pkg::INTV_W-1:0];
               end
               rec_new.duration = dur;
               if (cur.peak < dur) rec_new.peak = dur;
               rec_new.end_time = hold_ff.timestamp_us;
               rec_new.armed    = 1'b0;
               done             = 1'b1;
            end
         end
         setp_pkg::OP_READ: begin
            if (cur.start_count > setp_pkg::CNT_W'(setp_pkg::SAT_LIMIT)) begin
               rec_new.start_count = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      base_vld_in = base_vld_ff;
      stat_vld_in = stat_vld_ff;
      if (cmd.commit) begin
         if (hold_ff.opcode == setp_pkg::OP_CLEAR) stat_vld_in = '0;
         if (in_range) begin
            base_vld_in[hold_idx] = 1'b1;
            stat_vld_in[hold_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_vld_ff  <= '0;
         stat_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_vld_ff <= base_vld_in;
         stat_vld_ff <= stat_vld_in;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hold_ff <= req_data;
         rd_ff   <= mem_ff[req_idx];
      end
      if (cmd.commit && in_range) begin
         mem_ff[hold_idx] <= rec_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (in_range) begin
            rsp_data_ff.entry_count      <= rec_new.start_count;
            rsp_data_ff.interval_us      <= rec_new.interval;
            rsp_data_ff.last_duration_us <= rec_new.duration;
            rsp_data_ff.peak_duration_us <= rec_new.peak;
            rsp_data_ff.measured         <= done;
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

endmodule
`default_nettype wire

>>> hdl/slot_execution_time_profiler_core.sv
// Top level of the slot execution-time profiler.
// The request and its slot record are registered on the input transfer; the result register is loaded when it frees.
// A new item is accepted only after the read-modify-write of the slot memory for the last one commits.
// A pending result that is not taken holds the update until the result register frees.
// Reset clears control state and all slot valid bits at once; no clearing pass.
// Clear of all statistics takes effect at once through the valid bits.
`default_nettype none
module slot_execution_time_profiler_core #(
   parameter int SLOTS = setp_pkg::SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire setp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output setp_pkg::rsp_type      rsp_data
);

   setp_pkg::cmd_type cmd;
   setp_pkg::sts_type sts;

   setp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   setp_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
